// ----- rtl/ms_pkg.sv -----
// shared types and constants of the merge sorter
`default_nettype none

package ms_pkg;

    // default capacity of the element store
    localparam int MAX_ITEMS_DEF = 64;

    // width of one element
    localparam int VALUE_W = 32;

    typedef logic signed [VALUE_W-1:0] value_t;

    // commands from the controller to the datapath
    typedef struct packed {
        logic in_ready;  // load phase, input beats are taken
        logic seg_init;  // set up the next pair of runs
        logic step;      // write one merged element
        logic out_rd;    // address the store with the output index
        logic out_load;  // move one sorted element into the output register
    } ms_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic sort_done; // run width covers the whole set
        logic seg_last;  // this step writes the last element of the pair
        logic pass_end;  // no pair follows in this pass
        logic out_free;  // output register can take a beat
        logic out_last;  // the element being loaded is the final one
    } ms_sts_t;

endpackage

`default_nettype wire

// ----- rtl/ms_in_if.sv -----
// input channel of the merge sorter: one element per beat
`default_nettype none

interface ms_in_if;
    logic            valid;
    logic            ready;
    ms_pkg::value_t  value;
    logic            last_in;

    modport source (output valid, output value, output last_in, input ready);
    modport sink   (input valid, input value, input last_in, output ready);
endinterface

`default_nettype wire

// ----- rtl/ms_out_if.sv -----
// output channel of the merge sorter: one sorted element per beat
`default_nettype none

interface ms_out_if;
    logic            valid;
    logic            ready;
    ms_pkg::value_t  sorted_value;
    logic            last_out;
    logic            overflow;

    modport source (output valid, output sorted_value, output last_out, output overflow,
                    input ready);
    modport sink   (input valid, input sorted_value, input last_out, input overflow,
                    output ready);
endinterface

`default_nettype wire

// ----- rtl/ms_datapath.sv -----
// datapath: two element banks, merge counters, comparator and output register
`default_nettype none

module ms_datapath #(
    parameter int MAX_ITEMS = ms_pkg::MAX_ITEMS_DEF
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire ms_pkg::ms_cmd_t cmd,
    output ms_pkg::ms_sts_t      sts,
    input  wire logic            in_valid,
    input  wire ms_pkg::value_t  in_value,
    input  wire logic            in_last,
    input  wire logic            out_ready,
    output logic                 out_valid,
    output ms_pkg::value_t       out_value,
    output logic                 out_last,
    output logic                 out_ovf
);
    import ms_pkg::*;

    localparam int CNT_W  = $clog2(MAX_ITEMS + 1);
    localparam int ADDR_W = $clog2(MAX_ITEMS);
    localparam int SUM_W  = CNT_W + 2;
    localparam logic [CNT_W-1:0] FULL = CNT_W'(MAX_ITEMS);

    // element banks, the merge ping-pongs between them
    value_t mem_a [MAX_ITEMS];
    value_t mem_b [MAX_ITEMS];

    logic [CNT_W-1:0] count_reg;
    logic             ovf_seen_reg;
    logic             run_ovf_reg;
    logic [CNT_W-1:0] n_reg;
    logic [SUM_W-1:0] w_reg;
    logic [CNT_W-1:0] lo_reg;
    logic [CNT_W-1:0] i_reg;
    logic [CNT_W-1:0] j_reg;
    logic [CNT_W-1:0] k_reg;
    logic [CNT_W-1:0] mid_reg;
    logic [CNT_W-1:0] hi_reg;
    logic             src_reg;
    logic [CNT_W-1:0] o_reg;
    logic             ov_reg;
    value_t           ovalue_reg;
    logic             olast_reg;
    logic             oovf_reg;

    value_t a_i_reg, a_j_reg, b_i_reg, b_j_reg;

    logic             in_acc;
    logic             full;
    logic [SUM_W-1:0] n_ext;
    logic [SUM_W-1:0] lo_w;
    logic [SUM_W-1:0] lo_2w;
    logic [CNT_W-1:0] mid_c;
    logic [CNT_W-1:0] hi_c;
    logic [CNT_W-1:0] k_inc;
    logic [CNT_W-1:0] o_inc;
    value_t           d_i;
    value_t           d_j;
    logic             take_left;
    value_t           wd;
    logic             we_a;
    logic             we_b;
    logic [ADDR_W-1:0] wa_a;
    value_t           wd_a;
    logic [ADDR_W-1:0] ra_i;
    logic [ADDR_W-1:0] ra_j;

    // run bounds of the next pair
    assign in_acc = cmd.in_ready & in_valid;
    assign full   = (count_reg == FULL);
    assign n_ext  = {{(SUM_W-CNT_W){1'b0}}, n_reg};
    assign lo_w   = {{(SUM_W-CNT_W){1'b0}}, lo_reg} + w_reg;
    assign lo_2w  = {{(SUM_W-CNT_W){1'b0}}, lo_reg} + (w_reg << 1);
    assign mid_c  = (lo_w > n_ext)  ? n_reg : lo_w[CNT_W-1:0];
    assign hi_c   = (lo_2w > n_ext) ? n_reg : lo_2w[CNT_W-1:0];
    assign k_inc  = k_reg + 1'b1;
    assign o_inc  = o_reg + 1'b1;

    // merge compare, left wins on equal
    assign d_i       = src_reg ? b_i_reg : a_i_reg;
    assign d_j       = src_reg ? b_j_reg : a_j_reg;
    assign take_left = (i_reg < mid_reg) && ((j_reg >= hi_reg) || (d_i <= d_j));
    assign wd        = take_left ? d_i : d_j;

    // status
    assign sts.sort_done = (w_reg >= n_ext);
    assign sts.seg_last  = (k_inc == hi_reg);
    assign sts.pass_end  = (lo_2w >= n_ext);
    assign sts.out_free  = ~ov_reg | out_ready;
    assign sts.out_last  = (o_inc == n_reg);

    // bank ports
    assign we_a = (in_acc & ~full) | (cmd.step & src_reg);
    assign we_b = cmd.step & ~src_reg;
    assign wa_a = cmd.step ? k_reg[ADDR_W-1:0] : count_reg[ADDR_W-1:0];
    assign wd_a = cmd.step ? wd : in_value;
    assign ra_i = cmd.out_rd ? o_reg[ADDR_W-1:0] : i_reg[ADDR_W-1:0];
    assign ra_j = j_reg[ADDR_W-1:0];

    // bank a
    always_ff @(posedge clk)
    begin
        if (we_a)
        begin
            mem_a[wa_a] <= wd_a;
        end
        a_i_reg <= mem_a[ra_i];
        a_j_reg <= mem_a[ra_j];
    end

    // bank b
    always_ff @(posedge clk)
    begin
        if (we_b)
        begin
            mem_b[k_reg[ADDR_W-1:0]] <= wd;
        end
        b_i_reg <= mem_b[ra_i];
        b_j_reg <= mem_b[ra_j];
    end

    // load count, overflow tracking and merge counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            ovf_seen_reg <= 1'b0;
            run_ovf_reg  <= 1'b0;
            n_reg        <= '0;
            w_reg        <= '0;
            lo_reg       <= '0;
            i_reg        <= '0;
            j_reg        <= '0;
            k_reg        <= '0;
            mid_reg      <= '0;
            hi_reg       <= '0;
            src_reg      <= 1'b0;
            o_reg        <= '0;
        end
        else
        begin
            if (in_acc)
            begin
                if (in_last)
                begin
                    count_reg    <= '0;
                    ovf_seen_reg <= 1'b0;
                    n_reg        <= full ? count_reg : count_reg + 1'b1;
                    run_ovf_reg  <= ovf_seen_reg | full;
                    w_reg        <= SUM_W'(1);
                    lo_reg       <= '0;
                    src_reg      <= 1'b0;
                    o_reg        <= '0;
                end
                else if (full)
                begin
                    ovf_seen_reg <= 1'b1;
                end
                else
                begin
                    count_reg <= count_reg + 1'b1;
                end
            end
            if (cmd.seg_init)
            begin
                i_reg   <= lo_reg;
                j_reg   <= mid_c;
                k_reg   <= lo_reg;
                mid_reg <= mid_c;
                hi_reg  <= hi_c;
            end
            if (cmd.step)
            begin
                k_reg <= k_inc;
                if (take_left)
                begin
                    i_reg <= i_reg + 1'b1;
                end
                else
                begin
                    j_reg <= j_reg + 1'b1;
                end
                if (sts.seg_last)
                begin
                    if (sts.pass_end)
                    begin
                        lo_reg  <= '0;
                        w_reg   <= w_reg << 1;
                        src_reg <= ~src_reg;
                    end
                    else
                    begin
                        lo_reg <= lo_2w[CNT_W-1:0];
                    end
                end
            end
            if (cmd.out_load)
            begin
                o_reg <= o_inc;
            end
        end
    end

    // output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            ov_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            ov_reg <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            ovalue_reg <= d_i;
            olast_reg  <= sts.out_last;
            oovf_reg   <= run_ovf_reg;
        end
    end

    assign out_valid = ov_reg;
    assign out_value = ovalue_reg;
    assign out_last  = olast_reg;
    assign out_ovf   = oovf_reg;

endmodule

`default_nettype wire

// ----- rtl/ms_ctrl.sv -----
// controller: sequences load, merge passes and output of the merge sorter
`default_nettype none

module ms_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    input  wire logic            in_last,
    input  wire ms_pkg::ms_sts_t sts,
    output ms_pkg::ms_cmd_t      cmd
);
    import ms_pkg::*;

    localparam logic [2:0] ST_LOAD = 3'd0;
    localparam logic [2:0] ST_CHK  = 3'd1;
    localparam logic [2:0] ST_SEG  = 3'd2;
    localparam logic [2:0] ST_RD   = 3'd3;
    localparam logic [2:0] ST_MRG  = 3'd4;
    localparam logic [2:0] ST_ORD  = 3'd5;
    localparam logic [2:0] ST_OLD  = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_LOAD:
            begin
                cmd.in_ready = 1'b1;
                if (in_valid && in_last)
                begin
                    state_next = ST_CHK;
                end
            end
            ST_CHK:
            begin
                state_next = sts.sort_done ? ST_ORD : ST_SEG;
            end
            ST_SEG:
            begin
                cmd.seg_init = 1'b1;
                state_next   = ST_RD;
            end
            ST_RD:
            begin
                state_next = ST_MRG;
            end
            ST_MRG:
            begin
                cmd.step = 1'b1;
                if (sts.seg_last)
                begin
                    state_next = sts.pass_end ? ST_CHK : ST_SEG;
                end
                else
                begin
                    state_next = ST_RD;
                end
            end
            ST_ORD:
            begin
                cmd.out_rd = 1'b1;
                state_next = ST_OLD;
            end
            ST_OLD:
            begin
                cmd.out_rd = 1'b1;
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = sts.out_last ? ST_LOAD : ST_ORD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/merge_sorter.sv -----
// merge_sorter: sorts a set of signed values in ascending order, stable on ties
//
// Beats on the items channel carry one element each; last_in closes the set.
// Up to MAX_ITEMS elements are kept, later ones of the same set are dropped and
// every result of that run then carries overflow. Loading takes one beat per
// cycle. After the closing beat items.ready stays low while a bottom-up merge
// runs over two ping-pong banks: each pass sets up one pair of runs after the
// other and, for each element of the pair, reads the bank, then compares and
// writes; ceil(log2 n) passes are needed for n elements. The sorted run then
// leaves on the results channel, each beat read from the bank, then loaded
// into the output register, with last_out on the final beat. A stalled receiver
// holds the output register and the sequencer waits. Once the final beat sits in
// the output register the block takes the next set while that beat still waits.
// Reset (rst_n, asynchronous) empties the set and the output register; the
// element banks are not cleared, only entries of the current set are read.
`default_nettype none

module merge_sorter #(
    parameter int MAX_ITEMS = ms_pkg::MAX_ITEMS_DEF
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    ms_in_if.sink      items,
    ms_out_if.source   results
);
    import ms_pkg::*;

    ms_cmd_t cmd;
    ms_sts_t sts;

    // sequencer
    ms_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (items.valid),
        .in_last  (items.last_in),
        .sts      (sts),
        .cmd      (cmd)
    );

    // storage, merge logic and output register
    ms_datapath #(
        .MAX_ITEMS (MAX_ITEMS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .in_valid  (items.valid),
        .in_value  (items.value),
        .in_last   (items.last_in),
        .out_ready (results.ready),
        .out_valid (results.valid),
        .out_value (results.sorted_value),
        .out_last  (results.last_out),
        .out_ovf   (results.overflow)
    );

    assign items.ready = cmd.in_ready;

    // the output register is only loaded when it is free
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> sts.out_free)
        else $error("output register overwritten while a beat waits");

    // after the final sorted beat the block goes back to loading
    a_back_to_load: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.out_load && sts.out_last) |=> cmd.in_ready)
        else $error("block did not return to loading after the final beat");

    // loading, merging and output never overlap
    a_phases: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.in_ready, cmd.seg_init, cmd.step, cmd.out_rd}))
        else $error("controller issued overlapping commands");

endmodule

`default_nettype wire

// ----- test/tb_top.sv -----
// testbench of the merge sorter: directed and random sets checked beat by beat
`timescale 1ns / 1ps

module tb_top;
    import ms_pkg::*;

    localparam int MAX_ITEMS      = 64;
    localparam int DIRECTED_N     = 20;
    localparam int RANDOM_BEATS   = 500;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 20;

    // one row of the directed plan; typed rows close a one-element set
    typedef struct packed {
        value_t value;
        logic   last_in;
        logic   typed;
        value_t exp_value;
    } plan_row_t;

    // one expected result beat
    typedef struct packed {
        value_t value;
        logic   last_out;
        logic   overflow;
    } sorted_beat_t;

    logic clk;
    logic rst_n;

    ms_in_if  items_if ();
    ms_out_if results_if ();

    merge_sorter #(
        .MAX_ITEMS(MAX_ITEMS)
    ) u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .items   (items_if),
        .results (results_if)
    );

    // set being collected by the predictor and the results still owed
    value_t       pending_set [$];
    logic         set_overflow;
    sorted_beat_t sorted_expect [$];
    sorted_beat_t exp_beat;

    plan_row_t directed_rows [DIRECTED_N];

    int error_count;
    int beats_sent;
    int sets_closed;
    int overflow_sets;
    int results_checked;
    int idle_cycles;

    // clock, 12 ns period
    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // idle lengths: mostly short, now and then long
    function automatic int source_gap();
        if ($urandom_range(0, 3) != 0)
            return 0;
        return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
    endfunction

    function automatic int sink_stall();
        return ($urandom_range(0, 7) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 3);
    endfunction

    // value mix: extremes, a narrow band for ties, full range
    function automatic value_t pick_value();
        case ($urandom_range(0, 9))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7FFF_FFFF;
            2, 3:    return value_t'(int'($urandom_range(0, 8)) - 4);
            default: return value_t'($urandom);
        endcase
    endfunction

    // add a beat or flag overflow; on the last, stable ascending sort and queue the run
    task automatic predict_beat(input value_t v, input logic last);
        value_t key;
        int     j;
        if (pending_set.size() < MAX_ITEMS)
            pending_set.push_back(v);
        else
            set_overflow = 1'b1;
        if (last)
        begin
            for (int i = 1; i < pending_set.size(); i++)
            begin
                key = pending_set[i];
                j = i - 1;
                while (j >= 0 && pending_set[j] > key)
                begin
                    pending_set[j + 1] = pending_set[j];
                    j--;
                end
                pending_set[j + 1] = key;
            end
            foreach (pending_set[k])
                sorted_expect.push_back('{pending_set[k], k == pending_set.size() - 1,
                                          set_overflow});
            sets_closed++;
            if (set_overflow)
                overflow_sets++;
            pending_set.delete();
            set_overflow = 1'b0;
        end
    endtask

    // drive one beat, optionally after a gap, and hold it until taken
    task automatic send_beat(input value_t v, input logic last, input bit burst);
        int gap;
        gap = burst ? 0 : source_gap();
        if (gap > 0)
        begin
            items_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        items_if.valid   <= 1'b1;
        items_if.value   <= v;
        items_if.last_in <= last;
        @(posedge clk);
        while (!items_if.ready)
            @(posedge clk);
        beats_sent++;
    endtask

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && results_if.valid && results_if.ready)
        begin
            if (sorted_expect.size() == 0)
            begin
                $error("result beat with nothing expected: sorted_value %0d",
                       results_if.sorted_value);
                error_count++;
            end
            else
            begin
                exp_beat = sorted_expect.pop_front();
                results_checked++;
                if (results_if.sorted_value !== exp_beat.value)
                begin
                    $error("sorted_value: expected %0d, got %0d",
                           exp_beat.value, results_if.sorted_value);
                    error_count++;
                end
                if (results_if.last_out !== exp_beat.last_out)
                begin
                    $error("last_out: expected %0b, got %0b",
                           exp_beat.last_out, results_if.last_out);
                    error_count++;
                end
                if (results_if.overflow !== exp_beat.overflow)
                begin
                    $error("overflow: expected %0b, got %0b",
                           exp_beat.overflow, results_if.overflow);
                    error_count++;
                end
            end
        end
    end

    // receiver: stretches without stalls, otherwise bursts broken by stalls
    initial
    begin
        results_if.ready <= 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                results_if.ready <= 1'b1;
                repeat ($urandom_range(50, 200)) @(posedge clk);
            end
            else
            begin
                results_if.ready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge clk);
                results_if.ready <= 1'b0;
                repeat (sink_stall()) @(posedge clk);
            end
        end
    end

    // watchdog on cycles without any accepted beat
    initial
    begin
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((items_if.valid && items_if.ready) || (results_if.valid && results_if.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("timeout: no beat accepted for %0d cycles", WATCHDOG_LIMIT);
        $display("end of test: mismatches");
        $finish;
    end

    // stimulus
    initial
    begin
        int  set_len;
        bit  burst;

        error_count      = 0;
        beats_sent       = 0;
        sets_closed      = 0;
        overflow_sets    = 0;
        results_checked  = 0;
        set_overflow     = 1'b0;
        items_if.valid   <= 1'b0;
        items_if.value   <= '0;
        items_if.last_in <= 1'b0;

        // one-element sets of the extremes, zero and minus one, then ties, order and equal runs
        directed_rows = '{
            '{32'sh7FFF_FFFF, 1'b1, 1'b1, 32'sh7FFF_FFFF},
            '{32'sh8000_0000, 1'b1, 1'b1, 32'sh8000_0000},
            '{32'sh0000_0000, 1'b1, 1'b1, 32'sh0000_0000},
            '{32'shFFFF_FFFF, 1'b1, 1'b1, 32'shFFFF_FFFF},
            '{32'sh0000_0005, 1'b0, 1'b0, 32'sh0},
            '{32'shFFFF_FFFD, 1'b0, 1'b0, 32'sh0},
            '{32'sh0000_0005, 1'b0, 1'b0, 32'sh0},
            '{32'sh8000_0000, 1'b0, 1'b0, 32'sh0},
            '{32'sh7FFF_FFFF, 1'b0, 1'b0, 32'sh0},
            '{32'shFFFF_FFFD, 1'b0, 1'b0, 32'sh0},
            '{32'sh0000_0000, 1'b1, 1'b0, 32'sh0},
            '{32'sh0000_0003, 1'b0, 1'b0, 32'sh0},
            '{32'sh0000_0002, 1'b0, 1'b0, 32'sh0},
            '{32'sh0000_0001, 1'b0, 1'b0, 32'sh0},
            '{32'sh0000_0000, 1'b1, 1'b0, 32'sh0},
            '{32'sh0000_0007, 1'b0, 1'b0, 32'sh0},
            '{32'sh0000_0007, 1'b0, 1'b0, 32'sh0},
            '{32'sh0000_0007, 1'b1, 1'b0, 32'sh0},
            '{32'shFFFF_FFFF, 1'b0, 1'b0, 32'sh0},
            '{32'sh0000_0001, 1'b1, 1'b0, 32'sh0}
        };

        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed plan
        foreach (directed_rows[r])
        begin
            send_beat(directed_rows[r].value, directed_rows[r].last_in, 1'b0);
            if (directed_rows[r].typed)
            begin
                sorted_expect.push_back('{directed_rows[r].exp_value, 1'b1, 1'b0});
                sets_closed++;
            end
            else
                predict_beat(directed_rows[r].value, directed_rows[r].last_in);
        end

        // full store, one dropped beat, many dropped beats; then random sets
        for (int s = 0; beats_sent < DIRECTED_N + RANDOM_BEATS; s++)
        begin
            case (s)
                0:       set_len = MAX_ITEMS;
                1:       set_len = MAX_ITEMS + 1;
                2:       set_len = MAX_ITEMS + 16;
                default: set_len = ($urandom_range(0, 19) == 0) ? $urandom_range(60, 72)
                                                                : $urandom_range(1, 12);
            endcase
            burst = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < set_len; i++)
            begin
                value_t v;
                v = pick_value();
                send_beat(v, i == set_len - 1, burst);
                predict_beat(v, i == set_len - 1);
            end
        end
        items_if.valid <= 1'b0;

        // drain the outstanding results
        while (sorted_expect.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sorted_expect.size() != 0)
        begin
            $error("%0d expected result beats never arrived", sorted_expect.size());
            error_count++;
        end

        $display("%0d input beats in %0d sets sorted, %0d of them overflowed",
                 beats_sent, sets_closed, overflow_sets);
        $display("%0d result beats checked, %0d mismatches", results_checked, error_count);
        if (error_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/ms_pkg.sv
rtl/ms_in_if.sv
rtl/ms_out_if.sv
rtl/ms_datapath.sv
rtl/ms_ctrl.sv
rtl/merge_sorter.sv
test/tb_top.sv
